/* design/lsms_pkg.sv */
// Package for the LCD scanline mode sequencer: mode codes, timing limits,
// register indexes and the state and result records.
// No dependencies.
package lsms_pkg;

    localparam int unsigned ACCUM_W  = 10;
    localparam int unsigned LINE_W   = 8;
    localparam int unsigned ELAPSE_W = 6;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned IRQ_EN_W   = 3;

    localparam logic [ACCUM_W-1:0] OAM_CYCLES    = 10'd80;
    localparam logic [ACCUM_W-1:0] XFER_CYCLES   = 10'd172;
    localparam logic [ACCUM_W-1:0] HBLANK_CYCLES = 10'd204;
    localparam logic [ACCUM_W-1:0] VLINE_CYCLES  = 10'd456;

    localparam logic [LINE_W-1:0] VBLANK_FIRST = 8'd144;
    localparam logic [LINE_W-1:0] LAST_LINE    = 8'd153;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_LINE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ENABLES  = 8'd1;

    // Bit positions within irq_enables
    localparam int unsigned IRQ_EN_HBLANK = 0;
    localparam int unsigned IRQ_EN_VBLANK = 1;
    localparam int unsigned IRQ_EN_OAM    = 2;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [ACCUM_W-1:0] accum;
        t_mode              mode;
        logic [LINE_W-1:0]  line;
    } t_seq_state;

    typedef struct packed {
        t_mode             mode;
        logic [LINE_W-1:0] line;
        logic              coincidence;
        logic              stat_irq;
        logic              line_done;
        logic              frame_done;
    } t_result;

endpackage

/* design/lsms_step.sv */
// Next-state and result logic for one beat of the scanline sequencer.
// Depends on lsms_pkg.
module lsms_step (
    input  lsms_pkg::t_seq_state                 i_state,
    input  logic [lsms_pkg::ELAPSE_W-1:0]        i_elapsed,
    input  logic [lsms_pkg::LINE_W-1:0]          i_compare_line,
    input  logic [lsms_pkg::IRQ_EN_W-1:0]        i_irq_enables,
    output lsms_pkg::t_seq_state                 o_state,
    output lsms_pkg::t_result                    o_result
);
    import lsms_pkg::*;

    logic [ACCUM_W-1:0] sum;
    logic [LINE_W-1:0]  line_inc;

    assign sum      = i_state.accum + {{(ACCUM_W-ELAPSE_W){1'b0}}, i_elapsed};
    assign line_inc = i_state.line + {{(LINE_W-1){1'b0}}, 1'b1};

    always_comb begin
        o_state             = i_state;
        o_state.accum       = sum;
        o_result.stat_irq   = 1'b0;
        o_result.line_done  = 1'b0;
        o_result.frame_done = 1'b0;

        unique case (i_state.mode)
            MODE_HBLANK: begin
                if (sum >= HBLANK_CYCLES) begin
                    o_state.accum = '0;
                    o_state.line  = line_inc;
                    if (line_inc == VBLANK_FIRST) begin
                        o_state.mode      = MODE_VBLANK;
                        o_result.stat_irq = i_irq_enables[IRQ_EN_VBLANK];
                    end else begin
                        o_state.mode      = MODE_OAM;
                        o_result.stat_irq = i_irq_enables[IRQ_EN_OAM];
                    end
                end
            end
            MODE_VBLANK: begin
                if (sum >= VLINE_CYCLES) begin
                    o_state.accum = '0;
                    o_state.line  = line_inc;
                    // Past the last line: wrap to the top of the frame
                    if (line_inc > LAST_LINE) begin
                        o_state.line        = '0;
                        o_state.mode        = MODE_OAM;
                        o_result.frame_done = 1'b1;
                    end
                end
            end
            MODE_OAM: begin
                if (sum >= OAM_CYCLES) begin
                    o_state.accum = '0;
                    o_state.mode  = MODE_XFER;
                end
            end
            MODE_XFER: begin
                if (sum >= XFER_CYCLES) begin
                    o_state.accum      = '0;
                    o_state.mode       = MODE_HBLANK;
                    o_result.stat_irq  = i_irq_enables[IRQ_EN_HBLANK];
                    o_result.line_done = 1'b1;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase

        o_result.mode        = o_state.mode;
        o_result.line        = o_state.line;
        o_result.coincidence = (o_state.line == i_compare_line);
    end

endmodule

/* design/lcd_scanline_mode_sequencer.sv */
// Top level of the LCD scanline mode sequencer: state, configuration
// registers, output register and skid stage. Depends on lsms_pkg, lsms_step.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -------------------------------
//  in       sink       i_in_valid / o_in_stall   i_elapsed_cycles
//  out      source     o_out_valid / i_out_stall o_mode, o_current_line,
//                                                o_coincidence, o_stat_irq,
//                                                o_line_done, o_frame_done
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One beat per clock while the input is not stalled: the step logic is a single
// add and compare on the accumulator, and the result is registered.
// Synchronous active-low reset clears the sequencer to hblank, line 0, and
// empties the output and skid registers.
// A stalled result holds in the output register; one further beat lands in
// the skid register, and the input stalls only while the skid is occupied.
module lcd_scanline_mode_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [lsms_pkg::ELAPSE_W-1:0]       i_elapsed_cycles,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_mode,
    output logic [lsms_pkg::LINE_W-1:0]         o_current_line,
    output logic                                o_coincidence,
    output logic                                o_stat_irq,
    output logic                                o_line_done,
    output logic                                o_frame_done,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lsms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lsms_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lsms_pkg::*;

    // Sequencer state
    t_seq_state r_state;
    t_seq_state n_state;

    // Configuration registers
    logic [LINE_W-1:0]   r_compare_line;
    logic [IRQ_EN_W-1:0] r_irq_enables;

    // Output register and skid stage
    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    t_result step_result;
    logic    in_accept;
    logic    out_free;

    lsms_step u_step (
        .i_state        (r_state),
        .i_elapsed      (i_elapsed_cycles),
        .i_compare_line (r_compare_line),
        .i_irq_enables  (r_irq_enables),
        .o_state        (n_state),
        .o_result       (step_result)
    );

    // Stall only while the skid holds a beat
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    // Output register may load when empty or being taken this cycle
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Advance the sequencer on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.accum <= '0;
            r_state.mode  <= MODE_HBLANK;
            r_state.line  <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Register writes; unknown indexes drop silently
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compare_line <= '0;
            r_irq_enables  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_COMPARE_LINE) begin
                r_compare_line <= i_cfg_data[LINE_W-1:0];
            end else if (i_cfg_index == CFG_IRQ_ENABLES) begin
                r_irq_enables <= i_cfg_data[IRQ_EN_W-1:0];
            end
        end
    end

    // Output and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // Drain the skid first so beats leave in order
            r_out_valid  <= r_skid_valid || in_accept;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= step_result;
            end
        end else if (in_accept) begin
            r_skid <= step_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mode         = r_out.mode;
    assign o_current_line = r_out.line;
    assign o_coincidence  = r_out.coincidence;
    assign o_stat_irq     = r_out.stat_irq;
    assign o_line_done    = r_out.line_done;
    assign o_frame_done   = r_out.frame_done;

endmodule

/* design/lsms_checker.sv */
// Port-level checker for the scanline sequencer, bound to the top level.
// Depends on lsms_pkg and lcd_scanline_mode_sequencer.
module lsms_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [1:0]                      o_mode,
    input logic [lsms_pkg::LINE_W-1:0]     o_current_line,
    input logic                            o_stat_irq,
    input logic                            o_line_done,
    input logic                            o_frame_done
);
    import lsms_pkg::*;

    // Hold a stalled result unchanged
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mode)
            && $stable(o_current_line) && $stable(o_line_done))
        else $error("stalled result changed");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_current_line <= LAST_LINE)
        else $error("line counter out of range");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_mode == MODE_OAM && o_current_line == '0
            && !o_stat_irq)
        else $error("frame end without wrap to OAM scan at line 0");

    a_line_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_done |-> o_mode == MODE_HBLANK
            && o_current_line < VBLANK_FIRST)
        else $error("line end outside hblank of a visible line");

    a_vblank_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stat_irq && o_mode == MODE_VBLANK |-> o_current_line == VBLANK_FIRST)
        else $error("vblank interrupt away from first vblank line");

endmodule

bind lcd_scanline_mode_sequencer lsms_checker u_lsms_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_mode         (o_mode),
    .o_current_line (o_current_line),
    .o_stat_irq     (o_stat_irq),
    .o_line_done    (o_line_done),
    .o_frame_done   (o_frame_done)
);

/* tb/tb.sv */
// Self-checking bench for lcd_scanline_mode_sequencer: random and directed elapsed-cycle
// beats against a scanline timing predictor, with random idling on both channels.
// Depends on lsms_pkg and the sequencer RTL.
module tb;
    import lsms_pkg::*;

    localparam int unsigned SEG_BEATS      = 120;
    localparam int unsigned MIN_BEATS      = 600;
    localparam int unsigned QUIET_LIMIT    = 1000;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IRQ_ENABLES + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [ELAPSE_W-1:0]   i_elapsed_cycles = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_mode;
    logic [LINE_W-1:0]     o_current_line;
    logic                  o_coincidence;
    logic                  o_stat_irq;
    logic                  o_line_done;
    logic                  o_frame_done;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor state: shadow registers and sequencer state
    logic [LINE_W-1:0]   cmp_line_q = '0;
    logic [IRQ_EN_W-1:0] irq_en_q = '0;
    logic [ACCUM_W-1:0]  seq_accum = '0;
    t_mode               seq_mode = MODE_HBLANK;
    logic [LINE_W-1:0]   seq_line = '0;

    logic [ELAPSE_W-1:0] elapsed_q[$];
    t_result             status_q[$];
    t_result             next_status;
    t_result             want_status;
    t_result             seen_status;

    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 55;
    int unsigned beats_queued = 0;
    int unsigned beats_sent = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    // Walk one full line from reset with compare line 1 and all enables set:
    // idle beat, oam entry on an exact limit, exact oam and transfer limits,
    // then an hblank overrun whose leftover cycles are dropped.
    logic [ELAPSE_W-1:0] warmup_steps [18] = '{
        6'd0, 6'd63, 6'd63, 6'd63, 6'd15, 6'd63, 6'd16, 6'd1, 6'd63,
        6'd63, 6'd46, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd0
    };

    wire in_beat  = i_in_valid && !o_in_stall;
    wire out_beat = o_out_valid && !i_out_stall;
    wire cfg_beat = i_cfg_valid && o_cfg_ready;

    lcd_scanline_mode_sequencer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_elapsed_cycles (i_elapsed_cycles),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_mode           (o_mode),
        .o_current_line   (o_current_line),
        .o_coincidence    (o_coincidence),
        .o_stat_irq       (o_stat_irq),
        .o_line_done      (o_line_done),
        .o_frame_done     (o_frame_done),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Advance the scanline timing by one beat and return the status it produces.
    // At most one mode change per beat; any change clears the accumulator.
    function automatic t_result advance_scanline(input logic [ELAPSE_W-1:0] cyc);
        t_result r;
        r = '0;
        seq_accum = seq_accum + ACCUM_W'(cyc);
        case (seq_mode)
            MODE_HBLANK: begin
                if (seq_accum >= HBLANK_CYCLES) begin
                    seq_accum = '0;
                    seq_line  = seq_line + LINE_W'(1);
                    if (seq_line == VBLANK_FIRST) begin
                        r.stat_irq = irq_en_q[IRQ_EN_VBLANK];
                        seq_mode   = MODE_VBLANK;
                    end else begin
                        r.stat_irq = irq_en_q[IRQ_EN_OAM];
                        seq_mode   = MODE_OAM;
                    end
                end
            end
            MODE_VBLANK: begin
                if (seq_accum >= VLINE_CYCLES) begin
                    seq_accum = '0;
                    seq_line  = seq_line + LINE_W'(1);
                    // wrap the frame: back to oam scan with no interrupt
                    if (seq_line > LAST_LINE) begin
                        seq_line     = '0;
                        seq_mode     = MODE_OAM;
                        r.frame_done = 1'b1;
                    end
                end
            end
            MODE_OAM: begin
                if (seq_accum >= OAM_CYCLES) begin
                    seq_accum = '0;
                    seq_mode  = MODE_XFER;
                end
            end
            default: begin
                if (seq_accum >= XFER_CYCLES) begin
                    seq_accum   = '0;
                    seq_mode    = MODE_HBLANK;
                    r.stat_irq  = irq_en_q[IRQ_EN_HBLANK];
                    r.line_done = 1'b1;
                end
            end
        endcase
        r.mode        = seq_mode;
        r.line        = seq_line;
        r.coincidence = (seq_line == cmp_line_q);
        return r;
    endfunction

    // Mostly large steps so that whole lines go by; some zeros,
    // full-scale steps and uniform noise.
    function automatic logic [ELAPSE_W-1:0] pick_elapsed();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            return '0;
        if (r < 8)
            return '1;
        if (r < 20)
            return ELAPSE_W'($urandom_range(63));
        return ELAPSE_W'($urandom_range(63, 40));
    endfunction

    // Write one register and mirror it into the predictor's shadow copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_COMPARE_LINE)
            cmp_line_q = data;
        else if (idx == CFG_IRQ_ENABLES)
            irq_en_q = data[IRQ_EN_W-1:0];
    endtask

    // Hold the sender until every queued beat is in and every status is out.
    task automatic drain_status();
        while (beats_sent != beats_queued || status_q.size() != 0)
            @(posedge i_clk);
    endtask

    // New compare line, a write to an unused index, and an enable pattern.
    task automatic reconfigure(input int unsigned seg);
        logic [CFG_DATA_W-1:0] cmp;
        case ($urandom_range(5))
            0: cmp = '0;
            1: cmp = '1;
            2: cmp = LAST_LINE;
            3: cmp = VBLANK_FIRST;
            default: cmp = CFG_DATA_W'($urandom_range(LAST_LINE));
        endcase
        write_reg(CFG_COMPARE_LINE, cmp);
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                  CFG_DATA_W'($urandom()));
        case (seg % 3)
            0: write_reg(CFG_IRQ_ENABLES, '0);
            1: write_reg(CFG_IRQ_ENABLES, '1);
            default: write_reg(CFG_IRQ_ENABLES, CFG_DATA_W'($urandom()));
        endcase
    endtask

    // Driver: offer the next pending beat once the current one is taken,
    // predict the status of every accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                next_status = advance_scanline(i_elapsed_cycles);
                status_q.push_back(next_status);
                beats_sent++;
            end
            // a stalled beat must hold its payload
            if (!i_in_valid || !o_in_stall) begin
                if (elapsed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid       <= 1'b1;
                    i_elapsed_cycles <= elapsed_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each status beat against the oldest prediction, stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (out_beat) begin
                seen_status.mode        = t_mode'(o_mode);
                seen_status.line        = o_current_line;
                seen_status.coincidence = o_coincidence;
                seen_status.stat_irq    = o_stat_irq;
                seen_status.line_done   = o_line_done;
                seen_status.frame_done  = o_frame_done;
                if (status_q.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected status beat: mode=%0d line=%0d", o_mode,
                                 o_current_line);
                    mismatches++;
                end else begin
                    want_status = status_q.pop_front();
                    if (seen_status.mode !== want_status.mode
                            || seen_status.line !== want_status.line
                            || seen_status.coincidence !== want_status.coincidence
                            || seen_status.stat_irq !== want_status.stat_irq
                            || seen_status.line_done !== want_status.line_done
                            || seen_status.frame_done !== want_status.frame_done) begin
                        if (mismatches < REPORT_LIMIT)
                            $display({"status mismatch: exp mode=%0d line=%0d coin=%0b ",
                                      "irq=%0b ldone=%0b fdone=%0b, got mode=%0d line=%0d ",
                                      "coin=%0b irq=%0b ldone=%0b fdone=%0b"},
                                     want_status.mode, want_status.line,
                                     want_status.coincidence, want_status.stat_irq,
                                     want_status.line_done, want_status.frame_done,
                                     o_mode, o_current_line, o_coincidence, o_stat_irq,
                                     o_line_done, o_frame_done);
                        mismatches++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: end the run if no channel moves a beat for too long.
    always @(posedge i_clk) begin
        if (in_beat || out_beat || cfg_beat) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: reset, directed line walk, then random segments under three
    // idling regimes, reconfiguring while idle between segments.
    initial begin
        int unsigned phase_idx;
        int unsigned seg_in_phase;
        int unsigned seg_total;
        seg_total = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unused indexes first: they must leave both registers untouched
        write_reg(CFG_SPARE_LAST, '1);
        write_reg(CFG_SPARE_FIRST, '1);
        write_reg(CFG_COMPARE_LINE, 8'd1);
        write_reg(CFG_IRQ_ENABLES, '1);
        foreach (warmup_steps[k]) begin
            elapsed_q.push_back(warmup_steps[k]);
            beats_queued++;
        end

        for (phase_idx = 0; phase_idx < 3; phase_idx++) begin
            case (phase_idx)
                0: begin send_idle_pct = 35; recv_idle_pct = 55; end
                1: begin send_idle_pct = 55; recv_idle_pct = 35; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            seg_in_phase = 0;
            // the last phase runs on until the beat count is reached
            do begin
                drain_status();
                reconfigure(seg_total);
                repeat (SEG_BEATS) begin
                    elapsed_q.push_back(pick_elapsed());
                    beats_queued++;
                end
                seg_in_phase++;
                seg_total++;
                drain_status();
            end while (phase_idx < 2 ? seg_in_phase < 2 : beats_queued < MIN_BEATS);
        end

        drain_status();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (status_q.size() != 0)
            mismatches += status_q.size();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
